### design/iir_sixth_order_direct_form_one_core_assert.svh
// Assertion macros for the sixth-order IIR core.
// Used by the top level only; no other dependencies.
`ifndef IIR_SIXTH_ORDER_DIRECT_FORM_ONE_CORE_ASSERT_SVH
`define IIR_SIXTH_ORDER_DIRECT_FORM_ONE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IIRSX_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define IIRSX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/iirsx_pkg.sv
// Shared types and constants for the sixth-order IIR core.
// No dependencies.
package iirsx_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [DATA_W-1:0] SCALE_RESET = 32'd108668;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_COEF_0_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_COEF_2_3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_COEF_4_5 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_COEF_6   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_COEF_1_2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_COEF_3_4 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_COEF_5_6 = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_FEED_FWD,
      ST_FEED_BACK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // history chain control: advance shifts every cell one place,
   // insert puts a new value at the head instead of wrapping the tail
   typedef struct packed {
      logic advance;
      logic insert;
   } chain_ctl_type;

endpackage

### design/iirsx_cell.sv
// One history cell: a 32-bit value loaded from its neighbor on advance.
// Depends on iirsx_pkg.
module iirsx_cell
   import iirsx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [DATA_W-1:0] value_in,
   output logic [DATA_W-1:0] value_out
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in_sel;

   always_comb begin
      value_in_sel = advance ? value_in : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in_sel;
      end
   end

   assign value_out = value_ff;

endmodule

### design/iirsx_chain.sv
// Row of history cells, newest at the head, read at the tail.
// Rotating DEPTH times returns the row to its original order.
// Depends on iirsx_pkg and iirsx_cell.
module iirsx_chain
   import iirsx_pkg::*;
#(
   parameter int DEPTH = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  chain_ctl_type     ctl,
   input  logic [DATA_W-1:0] new_value,
   output logic [DATA_W-1:0] tail
);

   logic [DATA_W-1:0] link [0:DEPTH-1];
   logic [DATA_W-1:0] head_in;

   assign head_in = ctl.insert ? new_value : link[DEPTH-1];
   assign tail    = link[DEPTH-1];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         iirsx_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (ctl.advance),
            .value_in  (head_in),
            .value_out (link[i])
         );
      end else begin : g_body
         iirsx_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (ctl.advance),
            .value_in  (link[i-1]),
            .value_out (link[i])
         );
      end
   end

endmodule

### design/iir_sixth_order_direct_form_one_core.sv
// Sixth-order direct-form-I IIR filter core with a shared multiply-accumulate.
// Depends on iirsx_pkg, iirsx_chain and the assertion macro header.
//
// Each item is processed in turn by the single 32x32 multiply-accumulate,
// which walks ORDER+1 feedforward taps and ORDER feedback taps: the sample
// is scaled and pushed, each tap is visited, the product register is drained,
// and the result is rounded and emitted. The next item is taken in the emit
// cycle, so a new item is not taken before the last one is emitted. The result
// is held in an output register, so a stalled rsp side stalls the core only at
// emit.
// Histories rotate through rows of cells, the tail feeding the multiplier.
// Config writes must happen while no item is in flight.
`include "iir_sixth_order_direct_form_one_core_assert.svh"

module iir_sixth_order_direct_form_one_core
   import iirsx_pkg::*;
#(
   parameter int ORDER = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,    // [15:0] sample
   input  logic                  req_tlast,    // block_end
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,    // [31:0] filtered
   output logic                  rsp_tlast,    // block_end_out
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int K_W   = $clog2(ORDER + 1);
   localparam int SP_W  = SAMPLE_W + DATA_W + 1;
   localparam int ACC_W = 2 * DATA_W;

   localparam logic signed [SP_W-1:0]  SP_MAX = SP_W'(64'sd2147483647);
   localparam logic signed [SP_W-1:0]  SP_MIN = SP_W'(-64'sd2147483648);
   localparam logic signed [ACC_W-1:0] AC_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] AC_MIN = ACC_W'(-64'sd2147483648);

   // configuration registers
   logic [DATA_W-1:0] input_scale_ff;
   logic [DATA_W-1:0] ff_coef_ff [0:6];
   logic [DATA_W-1:0] fb_coef_ff [0:5];

   always_ff @(posedge clock) begin
      if (reset) begin
         input_scale_ff <= SCALE_RESET;
         for (int i = 0; i < 7; i++) ff_coef_ff[i] <= '0;
         for (int i = 0; i < 6; i++) fb_coef_ff[i] <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INPUT_SCALE: input_scale_ff <= csr_wr_data[31:0];
            CSR_FF_COEF_0_1: begin
               ff_coef_ff[0] <= csr_wr_data[31:0];
               ff_coef_ff[1] <= csr_wr_data[63:32];
            end
            CSR_FF_COEF_2_3: begin
               ff_coef_ff[2] <= csr_wr_data[31:0];
               ff_coef_ff[3] <= csr_wr_data[63:32];
            end
            CSR_FF_COEF_4_5: begin
               ff_coef_ff[4] <= csr_wr_data[31:0];
               ff_coef_ff[5] <= csr_wr_data[63:32];
            end
            CSR_FF_COEF_6: ff_coef_ff[6] <= csr_wr_data[31:0];
            CSR_FB_COEF_1_2: begin
               fb_coef_ff[0] <= csr_wr_data[31:0];
               fb_coef_ff[1] <= csr_wr_data[63:32];
            end
            CSR_FB_COEF_3_4: begin
               fb_coef_ff[2] <= csr_wr_data[31:0];
               fb_coef_ff[3] <= csr_wr_data[63:32];
            end
            CSR_FB_COEF_5_6: begin
               fb_coef_ff[4] <= csr_wr_data[31:0];
               fb_coef_ff[5] <= csr_wr_data[63:32];
            end
            default: ;
         endcase
      end
   end

   // control and datapath registers
   state_type               state_ff, state_in;
   logic [K_W-1:0]          tap_ff, tap_in;
   logic                    prod_valid_ff, prod_valid_in;
   logic signed [SP_W-1:0]  scale_prod_ff, scale_prod_in;
   logic                    block_end_ff;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_data_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic                    rsp_free;
   logic                    emit;
   chain_ctl_type           in_ctl, out_ctl;
   logic [DATA_W-1:0]       in_tail, out_tail;
   logic [DATA_W-1:0]       coef_mux, opnd_mux;
   logic signed [SP_W-1:0]  scaled_rnd;
   logic [DATA_W-1:0]       scaled_sat;
   logic signed [ACC_W-1:0] acc_rnd;
   logic [DATA_W-1:0]       y_sat;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   // sample * reciprocal gain, taken straight at accept
   assign scale_prod_in = $signed({{(SP_W-SAMPLE_W){req_tdata[15]}}, req_tdata})
                        * $signed({{(SP_W-DATA_W){1'b0}}, input_scale_ff});

   always_comb begin
      scaled_rnd = (scale_prod_ff + SP_W'(128)) >>> 8;
      if (scaled_rnd > SP_MAX) begin
         scaled_sat = 32'h7fff_ffff;
      end else if (scaled_rnd < SP_MIN) begin
         scaled_sat = 32'h8000_0000;
      end else begin
         scaled_sat = scaled_rnd[DATA_W-1:0];
      end
   end

   always_comb begin
      acc_rnd = (acc_ff + ACC_W'(32768)) >>> 16;
      if (acc_rnd > AC_MAX) begin
         y_sat = 32'h7fff_ffff;
      end else if (acc_rnd < AC_MIN) begin
         y_sat = 32'h8000_0000;
      end else begin
         y_sat = acc_rnd[DATA_W-1:0];
      end
   end

   iirsx_chain #(.DEPTH(ORDER + 1)) u_in_hist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (in_ctl),
      .new_value (scaled_sat),
      .tail      (in_tail)
   );

   iirsx_chain #(.DEPTH(ORDER)) u_out_hist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (out_ctl),
      .new_value (y_sat),
      .tail      (out_tail)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      in_ctl        = '0;
      out_ctl       = '0;
      coef_mux      = '0;
      opnd_mux      = '0;
      prod_valid_in = 1'b0;
      req_tready    = 1'b0;
      emit          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            in_ctl   = '{advance: 1'b1, insert: 1'b1};
            tap_in   = K_W'(ORDER);
            state_in = ST_FEED_FWD;
         end
         ST_FEED_FWD: begin
            // taps visited oldest first, the row wraps back to order
            in_ctl        = '{advance: 1'b1, insert: 1'b0};
            coef_mux      = ff_coef_ff[tap_ff];
            opnd_mux      = in_tail;
            prod_valid_in = 1'b1;
            if (tap_ff == '0) begin
               tap_in   = K_W'(ORDER);
               state_in = ST_FEED_BACK;
            end else begin
               tap_in = tap_ff - 1'b1;
            end
         end
         ST_FEED_BACK: begin
            out_ctl       = '{advance: 1'b1, insert: 1'b0};
            coef_mux      = fb_coef_ff[K_W'(tap_ff - 1'b1)];
            opnd_mux      = out_tail;
            prod_valid_in = 1'b1;
            tap_in        = tap_ff - 1'b1;
            if (tap_ff == K_W'(1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               emit       = 1'b1;
               out_ctl    = '{advance: 1'b1, insert: 1'b1};
               req_tready = 1'b1;
               state_in   = req_tvalid ? ST_PUSH : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign prod_in = $signed({{DATA_W{coef_mux[DATA_W-1]}}, coef_mux})
                  * $signed({{DATA_W{opnd_mux[DATA_W-1]}}, opnd_mux});

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == ST_PUSH) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + (prod_ff >>> 8);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_ff        <= '0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_ff        <= tap_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (accept) begin
         scale_prod_ff <= scale_prod_in;
         block_end_ff  <= req_tlast;
      end
      if (emit) begin
         rsp_data_ff <= y_sat;
         rsp_last_ff <= block_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `IIRSX_ASSERT_NEXT(a_accept_to_push, accept, state_ff == ST_PUSH, "accepted item not pushed")
   `IIRSX_ASSERT_IMPL(a_drain_after_fb, state_ff == ST_DRAIN, $past(state_ff) == ST_FEED_BACK, "drain out of sequence")
   `IIRSX_ASSERT_IMPL(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "result not from finish")
   `IIRSX_ASSERT_NEXT(a_finish_holds, state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready, state_ff == ST_FINISH, "finish left while output busy")

endmodule

### dv/iir_response_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sixth-order IIR core: a bit-exact filter predictor and
// the ordered store of outputs it predicts. Depends on iirsx_pkg.
package iir_response_tb_pkg;
   import iirsx_pkg::*;

   localparam int FILTER_ORDER = 6;

   typedef struct packed {
      logic [31:0] filtered;
      logic        block_end;
   } filter_output_type;

   class iir_response_model;
      bit [31:0]         input_scale;
      bit [63:0]         ff_pair[4];
      bit [63:0]         fb_pair[3];
      longint            x_hist[FILTER_ORDER+1];
      longint            y_hist[FILTER_ORDER];
      filter_output_type predicted_outputs[$];
      int                mismatch_count;
      int                checked_count;
      int                clipped_count;

      function new();
         input_scale = SCALE_RESET;
         foreach (ff_pair[i]) ff_pair[i] = '0;
         foreach (fb_pair[i]) fb_pair[i] = '0;
         foreach (x_hist[i]) x_hist[i] = 0;
         foreach (y_hist[i]) y_hist[i] = 0;
         mismatch_count = 0;
         checked_count  = 0;
         clipped_count  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] reg_index, logic [63:0] value);
         case (reg_index)
            CSR_INPUT_SCALE: input_scale = value[31:0];
            CSR_FF_COEF_0_1: ff_pair[0] = value;
            CSR_FF_COEF_2_3: ff_pair[1] = value;
            CSR_FF_COEF_4_5: ff_pair[2] = value;
            CSR_FF_COEF_6:   ff_pair[3] = {32'd0, value[31:0]};
            CSR_FB_COEF_1_2: fb_pair[0] = value;
            CSR_FB_COEF_3_4: fb_pair[1] = value;
            CSR_FB_COEF_5_6: fb_pair[2] = value;
            default: ;
         endcase
      endfunction

      // Q8.24 taps, two per register, lower index in the low half
      function longint ff_tap(int k);
         bit [63:0] pair;
         int        coef;
         pair = ff_pair[k / 2];
         coef = (k % 2) ? pair[63:32] : pair[31:0];
         return longint'(coef);
      endfunction

      // feedback taps start at index 1 and are stored negated
      function longint fb_tap(int k);
         bit [63:0] pair;
         int        coef;
         pair = fb_pair[(k - 1) / 2];
         coef = ((k - 1) % 2) ? pair[63:32] : pair[31:0];
         return longint'(coef);
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void accept_sample(logic [15:0] sample, logic block_end);
         shortint           s;
         longint            acc;
         longint            rounded;
         longint            y;
         int                k;
         filter_output_type item;
         s = sample;
         for (k = FILTER_ORDER; k > 0; k--) x_hist[k] = x_hist[k-1];
         // Q0 * Q8.24 -> Q16.16, round half up
         x_hist[0] = clamp32((longint'(s) * longint'(input_scale) + 128) >>> 8);
         acc = 0;
         for (k = 0; k <= FILTER_ORDER; k++) acc += (ff_tap(k) * x_hist[k]) >>> 8;
         for (k = 1; k <= FILTER_ORDER; k++) acc += (fb_tap(k) * y_hist[k-1]) >>> 8;
         rounded = (acc + 32768) >>> 16;
         y = clamp32(rounded);
         if (y != rounded) clipped_count++;
         for (k = FILTER_ORDER - 1; k > 0; k--) y_hist[k] = y_hist[k-1];
         y_hist[0] = y;
         item.filtered  = y[31:0];
         item.block_end = block_end;
         predicted_outputs.push_back(item);
      endfunction

      function void check_output(logic [31:0] filtered, logic block_end);
         filter_output_type want;
         if (predicted_outputs.size() == 0) begin
            $display("%0t: unexpected output: filtered=%h block_end=%b",
                     $time, filtered, block_end);
            mismatch_count++;
            return;
         end
         want = predicted_outputs.pop_front();
         checked_count++;
         if (filtered !== want.filtered) begin
            $display("%0t: filtered mismatch: expected %h, actual %h",
                     $time, want.filtered, filtered);
            mismatch_count++;
         end
         if (block_end !== want.block_end) begin
            $display("%0t: block_end mismatch: expected %b, actual %b",
                     $time, want.block_end, block_end);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return predicted_outputs.size();
      endfunction
   endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the sixth-order IIR core: streams samples under several
// filter settings and checks every output. Depends on iirsx_pkg,
// iir_response_tb_pkg and the core RTL.
module tb_top;
   import iirsx_pkg::*;
   import iir_response_tb_pkg::*;

   localparam int RANDOM_SETTINGS     = 8;
   localparam int SAMPLES_PER_SETTING = 203;
   localparam int RSP_HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES        = 40;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   iir_response_model filter_model;
   int                send_idle_pct    = 37;
   int                rsp_idle_pct     = 87;
   bit                rsp_hold_request = 1'b0;
   int                samples_sent     = 0;
   int                settings_used    = 0;
   logic [31:0]       ff_taps[7];
   logic [31:0]       fb_taps[7];   // index 0 unused

   iir_sixth_order_direct_form_one_core #(.ORDER(FILTER_ORDER)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [15:0] sample
      .req_tlast   (req_tlast),    // block_end
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [31:0] filtered
      .rsp_tlast   (rsp_tlast),    // block_end_out
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic update_idle_mode();
      if (samples_sent < 550) begin
         send_idle_pct = 37;
         rsp_idle_pct  = 87;
      end else if (samples_sent < 1100) begin
         send_idle_pct = 87;
         rsp_idle_pct  = 37;
      end else begin
         send_idle_pct = 0;
         rsp_idle_pct  = 0;
      end
   endtask

   task automatic send_sample(logic [15:0] sample, logic block_end);
      update_idle_mode();
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata  = 16'($urandom);
         req_tlast  = 1'($urandom);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = sample;
      req_tlast  = block_end;
      do @(posedge clock); while (req_tready !== 1'b1);
      filter_model.accept_sample(sample, block_end);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_outputs();
      req_tvalid = 1'b0;
      while (filter_model.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] reg_index, logic [63:0] value);
      csr_wr_en   = 1'b1;
      csr_index   = reg_index;
      csr_wr_data = value;
      filter_model.write_reg(reg_index, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // upper halves of the 32-bit registers get junk: it must be dropped
   task automatic load_setting(logic [31:0] scale);
      write_reg(CSR_INPUT_SCALE, {32'($urandom), scale});
      write_reg(CSR_FF_COEF_0_1, {ff_taps[1], ff_taps[0]});
      write_reg(CSR_FF_COEF_2_3, {ff_taps[3], ff_taps[2]});
      write_reg(CSR_FF_COEF_4_5, {ff_taps[5], ff_taps[4]});
      write_reg(CSR_FF_COEF_6,   {32'($urandom), ff_taps[6]});
      write_reg(CSR_FB_COEF_1_2, {fb_taps[2], fb_taps[1]});
      write_reg(CSR_FB_COEF_3_4, {fb_taps[4], fb_taps[3]});
      write_reg(CSR_FB_COEF_5_6, {fb_taps[6], fb_taps[5]});
      settings_used++;
   endtask

   function void fill_taps(logic [31:0] ff_value, logic [31:0] fb_value);
      foreach (ff_taps[i]) ff_taps[i] = ff_value;
      foreach (fb_taps[i]) fb_taps[i] = fb_value;
   endfunction

   // narrow taps keep the loop stable (|a| sum <= 0.75) so outputs stay in range
   function automatic logic [31:0] random_tap(bit feedback, bit wide);
      logic [31:0] span;
      if (wide) return $urandom;
      span = feedback ? 32'h0020_0000 : 32'h0040_0000;
      return $urandom_range(2 * span - 1) - span;
   endfunction

   function automatic logic [15:0] random_sample();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         1, 2:    return 16'($urandom_range(511) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         filter_model.check_output(rsp_tdata, rsp_tlast);
   end

   initial begin : rsp_side
      int hold_count;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready       = 1'b0;
            for (hold_count = 0; hold_count < RSP_HOLD_CYCLES; hold_count++)
               @(negedge clock);
         end
         rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : stimulus
      int          setting;
      int          n;
      bit          wide;
      logic [31:0] scale;
      filter_model = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset setting: all taps zero
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h0000, 1'b0);
      wait_for_outputs();

      // unit gain, largest scale: scaled sample clips both ways
      fill_taps('0, '0);
      ff_taps[0] = 32'h0100_0000;
      load_setting(32'hFFFF_FFFF);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0001, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b1);
      wait_for_outputs();

      // largest positive taps: accumulator clips
      fill_taps(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      load_setting(32'h0100_0000);
      repeat (3) send_sample(16'h7FFF, 1'b0);
      repeat (3) send_sample(16'h8000, 1'b1);
      wait_for_outputs();

      // most negative taps, zero scale: only the histories contribute
      fill_taps(32'h8000_0000, 32'h8000_0000);
      load_setting(32'h0000_0000);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h1234, 1'b0);
      send_sample(16'h0000, 1'b1);
      wait_for_outputs();

      // mild mixed-sign filter at the reset gain
      fill_taps('0, '0);
      ff_taps[0] = 32'h0080_0000;
      ff_taps[1] = 32'hFF80_0000;
      fb_taps[1] = 32'h0040_0000;
      fb_taps[6] = 32'hFFC0_0000;
      load_setting(SCALE_RESET);
      for (n = 0; n < 6; n++) send_sample(random_sample(), n[0]);
      wait_for_outputs();

      for (setting = 0; setting < RANDOM_SETTINGS; setting++) begin
         wide = (setting % 4 == 3);
         foreach (ff_taps[i]) ff_taps[i] = random_tap(1'b0, wide);
         foreach (fb_taps[i]) fb_taps[i] = random_tap(1'b1, wide);
         case ($urandom_range(3))
            0:       scale = SCALE_RESET;
            1:       scale = 32'h0100_0000;
            2:       scale = $urandom_range(32'h0200_0000);
            default: scale = wide ? $urandom : $urandom_range(32'h0040_0000);
         endcase
         load_setting(scale);
         for (n = 0; n < SAMPLES_PER_SETTING; n++) begin
            // long output stall while samples keep coming
            if (setting == 6 && n == 100) rsp_hold_request = 1'b1;
            send_sample(random_sample(), $urandom_range(7) == 0);
         end
         wait_for_outputs();
      end

      $display("Checked %0d outputs from %0d samples over %0d filter settings, %0d clipped.",
               filter_model.checked_count, samples_sent, settings_used,
               filter_model.clipped_count);
      $display("Included idle and stall mixes on both sides and a %0d-cycle output stall.",
               RSP_HOLD_CYCLES);
      if (filter_model.mismatch_count == 0) begin
         $display("PASS iir_sixth_order_direct_form_one_core");
      end else begin
         $display("FAIL iir_sixth_order_direct_form_one_core");
      end
      $finish;
   end

   initial begin : watchdog
      #(4_000_000);
      $display("Timeout with %0d outputs still expected.", filter_model.pending());
      $display("FAIL iir_sixth_order_direct_form_one_core");
      $finish;
   end

endmodule
